// ===== rtl/core/orca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle painting package
// Shared constants and types for the visible area by color block.
// ----------------------------------------------------------------------------
package orca_pkg;

    localparam int MAX_FRAGMENTS = 4096;
    localparam int COORD_BITS    = 16;
    localparam int COLOR_BITS    = 12;
    localparam int IDX_BITS      = $clog2(MAX_FRAGMENTS);
    localparam int CNT_BITS      = IDX_BITS + 1;
    localparam int AREA_BITS     = 32;

    localparam logic [1:0] ACT_PAINT   = 2'd0;
    localparam logic [1:0] ACT_QUERY   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BG     = 2'd2;

    typedef struct packed {
        logic [COORD_BITS-1:0] lx;
        logic [COORD_BITS-1:0] ly;
        logic [COORD_BITS-1:0] rx;
        logic [COORD_BITS-1:0] ry;
    } box_t;

    typedef struct packed {
        box_t                  box;
        logic [COLOR_BITS-1:0] hue;
        logic                  retired;
    } frag_t;

endpackage
`default_nettype wire

// ===== rtl/core/overlapping_rectangle_color_area.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Overlapping rectangle color area
// Fragment table painter with per-color visible area query.
// ----------------------------------------------------------------------------
// One item is handled at a time. A paint first writes the painted rectangle,
// then visits every fragment that existed before it; each visit reads the
// fragment, then tests it and, for an overlapped fragment, retires it and
// writes each side piece in turn. A query visits each stored fragment in
// turn: read, area product, accumulate. The single-port fragment memory
// makes these steps take turns.
// The result waits in an output register; the next item is accepted while
// it is held. Register writes take effect at the next restart.
module overlapping_rectangle_color_area
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [orca_pkg::COORD_BITS-1:0] left_x,
    input  wire logic [orca_pkg::COORD_BITS-1:0] bottom_y,
    input  wire logic [orca_pkg::COORD_BITS-1:0] right_x,
    input  wire logic [orca_pkg::COORD_BITS-1:0] top_y,
    input  wire logic [orca_pkg::COLOR_BITS-1:0] paint_color,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [orca_pkg::AREA_BITS-1:0] visible_area,
    output logic             overflow
);

    localparam int CB = orca_pkg::COORD_BITS;
    localparam int HB = orca_pkg::COLOR_BITS;
    localparam int IB = orca_pkg::IDX_BITS;
    localparam int NB = orca_pkg::CNT_BITS;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_READ  = 9'b000000010,
        ST_EVAL  = 9'b000000100,
        ST_PUSH  = 9'b000001000,
        ST_QREAD = 9'b000010000,
        ST_QWAIT = 9'b000100000,
        ST_QMUL  = 9'b001000000,
        ST_QADD  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    // Configuration registers.
    logic [CB-1:0] width_reg;
    logic [CB-1:0] height_reg;
    logic [HB-1:0] bg_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '1;
            height_reg <= '1;
            bg_reg     <= HB'(1);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                orca_pkg::REG_WIDTH:  width_reg  <= pwdata[CB-1:0];
                orca_pkg::REG_HEIGHT: height_reg <= pwdata[CB-1:0];
                orca_pkg::REG_BG:     bg_reg     <= pwdata[HB-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            orca_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            orca_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            orca_pkg::REG_BG:     prdata = 32'(bg_reg);
            default:              prdata = '0;
        endcase
    end

    // Fragment memory, one port, registered read.
    orca_pkg::frag_t mem [orca_pkg::MAX_FRAGMENTS];
    orca_pkg::frag_t rd_data;
    logic            mem_we;
    logic [IB-1:0]   mem_addr;
    orca_pkg::frag_t mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data <= mem[mem_addr];
    end

    // Control and working registers.
    state_t        state_reg, state_next;
    logic [NB-1:0] count_reg, count_next;
    logic [NB-1:0] before_reg, before_next;
    logic [NB-1:0] idx_reg, idx_next;
    logic          ovf_reg, ovf_next;
    logic          ovalid_reg, ovalid_next;
    logic [31:0]   area_reg, area_next;
    logic          oovf_reg, oovf_next;
    logic [31:0]   sum_reg, sum_next;
    logic [31:0]   prod_reg, prod_next;
    logic          pvalid_reg, pvalid_next;
    logic [CB-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [HB-1:0] hue_reg;
    logic [1:0]    act_reg;
    orca_pkg::frag_t frag_reg, frag_next;
    logic [3:0]    pend_reg, pend_next;
    logic          init_reg, init_next;

    logic          accept;
    logic          out_free;

    assign out_free = !ovalid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    assign out_valid    = ovalid_reg;
    assign visible_area = area_reg;
    assign overflow     = oovf_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            x1_reg  <= left_x;
            y1_reg  <= bottom_y;
            x2_reg  <= right_x;
            y2_reg  <= top_y;
            hue_reg <= paint_color;
        end
    end

    // Overlap test and side piece geometry for the fragment just read.
    orca_pkg::box_t fb;
    logic           hit;
    logic [CB-1:0]  mx, nx;
    logic [3:0]     sides;
    orca_pkg::box_t piece;
    logic [1:0]     psel_idx;
    logic [CB-1:0]  dx, dy;

    assign fb  = rd_data.box;
    assign hit = !rd_data.retired && !(x1_reg >= fb.rx || x2_reg <= fb.lx ||
                 y1_reg >= fb.ry || y2_reg <= fb.ly);

    always_comb
    begin
        mx = (frag_reg.box.lx > x1_reg) ? frag_reg.box.lx : x1_reg;
        nx = (frag_reg.box.rx < x2_reg) ? frag_reg.box.rx : x2_reg;
        sides[0] = (x1_reg > fb.lx) && (x1_reg < fb.rx);
        sides[1] = (y1_reg > fb.ly) && (y1_reg < fb.ry);
        sides[2] = (x2_reg > fb.lx) && (x2_reg < fb.rx);
        sides[3] = (y2_reg > fb.ly) && (y2_reg < fb.ry);
        // Lowest pending side goes first: left, bottom, right, top.
        if (pend_reg[0])      psel_idx = 2'd0;
        else if (pend_reg[1]) psel_idx = 2'd1;
        else if (pend_reg[2]) psel_idx = 2'd2;
        else                  psel_idx = 2'd3;
        piece = frag_reg.box;
        case (psel_idx)
            2'd0: piece.rx = x1_reg;
            2'd1: begin piece.lx = mx; piece.rx = nx; piece.ry = y1_reg; end
            2'd2: piece.lx = x2_reg;
            default: begin piece.lx = mx; piece.rx = nx; piece.ly = y2_reg; end
        endcase
        dx = rd_data.box.rx - rd_data.box.lx;
        dy = rd_data.box.ry - rd_data.box.ly;
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        before_next = before_reg;
        idx_next    = idx_reg;
        ovf_next    = ovf_reg;
        ovalid_next = ovalid_reg;
        area_next   = area_reg;
        oovf_next   = oovf_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        pvalid_next = 1'b0;
        frag_next   = frag_reg;
        pend_next   = pend_reg;
        init_next   = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = idx_reg[IB-1:0];
        mem_wdata   = '0;

        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;

        // Canvas load after reset or a restart.
        if (init_reg)
        begin
            mem_we    = 1'b1;
            mem_addr  = '0;
            mem_wdata = '{box: '{lx: '0, ly: '0, rx: width_reg, ry: height_reg},
                          hue: bg_reg, retired: 1'b0};
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    sum_next = '0;
                    case (action)
                        orca_pkg::ACT_PAINT:
                        begin
                            if (right_x <= left_x || top_y <= bottom_y)
                                state_next = ST_DONE;
                            else
                            begin
                                before_next = count_reg;
                                frag_next = '{box: '{lx: left_x, ly: bottom_y,
                                    rx: right_x, ry: top_y}, hue: paint_color,
                                    retired: 1'b0};
                                pend_next = 4'b0000;
                                state_next = ST_PUSH;
                            end
                        end
                        orca_pkg::ACT_QUERY:   state_next = ST_QREAD;
                        orca_pkg::ACT_RESTART:
                        begin
                            count_next = NB'(1);
                            ovf_next   = 1'b0;
                            init_next  = 1'b1;
                            state_next = ST_DONE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_PUSH:
            begin
                // Write the painted rectangle (pend empty) or one side piece.
                if (count_reg >= NB'(orca_pkg::MAX_FRAGMENTS))
                    ovf_next = 1'b1;
                else
                begin
                    mem_we    = 1'b1;
                    mem_addr  = count_reg[IB-1:0];
                    mem_wdata = frag_reg;
                    if (pend_reg != 4'b0000)
                        mem_wdata.box = piece;
                    count_next = count_reg + NB'(1);
                end
                if (pend_reg != 4'b0000)
                    pend_next[psel_idx] = 1'b0;
                if (pend_reg == 4'b0000 || $countones(pend_reg) == 1)
                    state_next = ST_READ;
                else
                    state_next = ST_PUSH;
            end
            ST_READ:
            begin
                if (idx_reg >= before_reg)
                    state_next = ST_DONE;
                else
                begin
                    mem_addr   = idx_reg[IB-1:0];
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                idx_next = idx_reg + NB'(1);
                if (hit)
                begin
                    // Retire the entry in place; pieces follow.
                    mem_we    = 1'b1;
                    mem_addr  = idx_reg[IB-1:0];
                    mem_wdata = rd_data;
                    mem_wdata.retired = 1'b1;
                    frag_next = rd_data;
                    pend_next = sides;
                    state_next = (sides != 4'b0000) ? ST_PUSH : ST_READ;
                end
                else
                    state_next = ST_READ;
            end
            ST_QREAD:
            begin
                mem_addr = idx_reg[IB-1:0];
                if (idx_reg >= count_reg)
                    state_next = ST_QADD;
                else
                begin
                    idx_next   = idx_reg + NB'(1);
                    state_next = ST_QWAIT;
                end
            end
            ST_QWAIT:
            begin
                // Data of entry idx-1 is valid; form its area.
                prod_next = 32'(dx) * 32'(dy);
                pvalid_next = !rd_data.retired && rd_data.hue == hue_reg &&
                              rd_data.box.rx > rd_data.box.lx &&
                              rd_data.box.ry > rd_data.box.ly;
                state_next = ST_QMUL;
            end
            ST_QMUL:
            begin
                if (pvalid_reg)
                begin
                    if ({1'b0, sum_reg} + {1'b0, prod_reg} > 33'hFFFFFFFF)
                        sum_next = '1;
                    else
                        sum_next = sum_reg + prod_reg;
                end
                state_next = ST_QREAD;
            end
            ST_QADD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    area_next   = (act_reg == orca_pkg::ACT_QUERY) ? sum_reg : '0;
                    oovf_next   = ovf_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= NB'(1);
            before_reg <= '0;
            idx_reg    <= '0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            pend_reg   <= '0;
            pvalid_reg <= 1'b0;
            init_reg   <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            before_reg <= before_next;
            idx_reg    <= idx_next;
            ovf_reg    <= ovf_next;
            ovalid_reg <= ovalid_next;
            pend_reg   <= pend_next;
            pvalid_reg <= pvalid_next;
            init_reg   <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        area_reg <= area_next;
        oovf_reg <= oovf_next;
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        frag_reg <= frag_next;
    end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle painting area testbench
// Drives paint, query and restart beats into the fragment table block,
// predicts each result with a local fragment table, and checks every
// result beat against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HALF_PERIOD = 6;
    localparam int NUM_RANDOM  = 48;
    localparam int NUM_DIRECTED = 20;
    localparam int CB = orca_pkg::COORD_BITS;
    localparam int HB = orca_pkg::COLOR_BITS;
    localparam int NFRAG = orca_pkg::MAX_FRAGMENTS;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = orca_pkg::ACT_PAINT;
    logic [CB-1:0] left_x = '0;
    logic [CB-1:0] bottom_y = '0;
    logic [CB-1:0] right_x = '0;
    logic [CB-1:0] top_y = '0;
    logic [HB-1:0] paint_color = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [orca_pkg::AREA_BITS-1:0] visible_area;
    logic        overflow;

    typedef struct {
        logic [1:0]    act;
        logic [CB-1:0] x1, y1, x2, y2;
        logic [HB-1:0] hue;
    } paint_item_t;

    typedef struct {
        logic [orca_pkg::AREA_BITS-1:0] area;
        logic                           ovf;
    } area_result_t;

    // Directed row: the beat, and an optional typed-in expectation.
    typedef struct {
        paint_item_t  item;
        logic         known;
        area_result_t want;
    } directed_row_t;

    overlapping_rectangle_color_area dut (.*);

    always #(HALF_PERIOD) clk = ~clk;

    // Predictor state: a copy of the fragment table and the registers.
    orca_pkg::box_t        pred_box [NFRAG];
    logic [HB-1:0]         pred_hue [NFRAG];
    logic                  pred_dead [NFRAG];
    int                    pred_count;
    logic                  pred_ovf;
    logic [15:0]           cfg_width = 16'hFFFF;
    logic [15:0]           cfg_height = 16'hFFFF;
    logic [11:0]           cfg_bg = 12'd1;

    area_result_t pending_areas[$];
    int           error_count = 0;
    bit           long_hold = 1'b0;

    task automatic append_fragment(input int lx, input int ly, input int rx,
                                   input int ry, input logic [HB-1:0] h);
        if (pred_count >= NFRAG)
        begin
            pred_ovf = 1'b1;
        end
        else
        begin
            pred_box[pred_count] = '{lx[15:0], ly[15:0], rx[15:0], ry[15:0]};
            pred_hue[pred_count] = h;
            pred_dead[pred_count] = 1'b0;
            pred_count++;
        end
    endtask

    task automatic reload_canvas();
        pred_count = 0;
        pred_ovf = 1'b0;
        append_fragment(0, 0, cfg_width, cfg_height, cfg_bg);
    endtask

    // Compute the result of one beat and update the predicted table.
    task automatic predict_area(input paint_item_t it, output area_result_t r);
        int older;
        int lx, ly, rx, ry, mx, nx;
        int x1, y1, x2, y2;
        longint sum;
        x1 = it.x1; y1 = it.y1; x2 = it.x2; y2 = it.y2;
        r.area = '0;
        if (it.act == orca_pkg::ACT_PAINT && x2 > x1 && y2 > y1)
        begin
            older = pred_count;
            append_fragment(x1, y1, x2, y2, it.hue);
            for (int k = 0; k < older; k++)
            begin
                lx = pred_box[k].lx; ly = pred_box[k].ly;
                rx = pred_box[k].rx; ry = pred_box[k].ry;
                if (pred_dead[k] || x1 >= rx || x2 <= lx || y1 >= ry || y2 <= ly)
                    continue;
                mx = (lx > x1) ? lx : x1;
                nx = (rx < x2) ? rx : x2;
                if (x1 > lx && x1 < rx) append_fragment(lx, ly, x1, ry, pred_hue[k]);
                if (y1 > ly && y1 < ry) append_fragment(mx, ly, nx, y1, pred_hue[k]);
                if (x2 > lx && x2 < rx) append_fragment(x2, ly, rx, ry, pred_hue[k]);
                if (y2 > ly && y2 < ry) append_fragment(mx, y2, nx, ry, pred_hue[k]);
                pred_dead[k] = 1'b1;
            end
        end
        else if (it.act == orca_pkg::ACT_QUERY)
        begin
            sum = 0;
            for (int k = 0; k < pred_count; k++)
            begin
                if (pred_dead[k] || pred_hue[k] != it.hue)
                    continue;
                if (pred_box[k].rx > pred_box[k].lx && pred_box[k].ry > pred_box[k].ly)
                    sum += longint'(pred_box[k].rx - pred_box[k].lx) *
                           longint'(pred_box[k].ry - pred_box[k].ly);
                if (sum > 64'hFFFF_FFFF)
                    sum = 64'hFFFF_FFFF;
            end
            r.area = sum[31:0];
        end
        else if (it.act == orca_pkg::ACT_RESTART)
        begin
            reload_canvas();
        end
        r.ovf = pred_ovf;
    endtask

    // Offer one beat, holding it until accepted.
    task automatic send_beat(input paint_item_t it);
        in_valid <= 1'b1;
        action <= it.act;
        left_x <= it.x1; bottom_y <= it.y1;
        right_x <= it.x2; top_y <= it.y2;
        paint_color <= it.hue;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    task automatic push_beat(input paint_item_t it, input logic known,
                             input area_result_t want);
        area_result_t r;
        predict_area(it, r);
        if (known && (r.area !== want.area || r.ovf !== want.ovf))
        begin
            $error("directed row disagrees with predictor: area %0d ovf %0b",
                   r.area, r.ovf);
            error_count++;
        end
        pending_areas.push_back(r);
        send_beat(it);
    endtask

    // Setup and access phases, then the bus returns to idle.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge clk);
        case (idx)
            orca_pkg::REG_WIDTH:  cfg_width = data[15:0];
            orca_pkg::REG_HEIGHT: cfg_height = data[15:0];
            default:              cfg_bg = data[11:0];
        endcase
    endtask

    // Wait until every result has arrived, then a settling pause.
    task automatic drain();
        drop_valid();
        while (pending_areas.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic paint_item_t make_item(input logic [1:0] a, input int x1,
                                              input int y1, input int x2,
                                              input int y2, input int h);
        paint_item_t it;
        it.act = a;
        it.x1 = x1[15:0]; it.y1 = y1[15:0];
        it.x2 = x2[15:0]; it.y2 = y2[15:0];
        it.hue = h[11:0];
        return it;
    endfunction

    // Random beat; paints mostly fall inside a small canvas so pieces stay few.
    function automatic paint_item_t random_item(input int span);
        paint_item_t it;
        int pick, a, b, c, d;
        pick = $urandom_range(0, 99);
        a = $urandom_range(0, span); b = $urandom_range(0, span);
        c = $urandom_range(0, span); d = $urandom_range(0, span);
        if (pick < 60)
        begin
            if (a > c) begin int t = a; a = c; c = t; end
            if (b > d) begin int t = b; b = d; d = t; end
            it = make_item(orca_pkg::ACT_PAINT, a, b, c + 1, d + 1,
                           $urandom_range(0, 7));
        end
        else if (pick < 88)
            it = make_item(orca_pkg::ACT_QUERY, a, b, c, d, $urandom_range(0, 7));
        else if (pick < 92)
            it = make_item(orca_pkg::ACT_RESTART, a, b, c, d, $urandom_range(0, 4095));
        else if (pick < 96)
            it = make_item(ACT_UNUSED, a, b, c, d, $urandom_range(0, 4095));
        else
            it = make_item(2'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                           $urandom, $urandom_range(0, 4095));
        return it;
    endfunction

    // Receiver stall pattern, with one long hold-off.
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                hold = 0;
                while (hold < 400)
                begin
                    @(negedge clk);
                    hold++;
                end
                out_stall <= 1'b0;
                long_hold = 1'b0;
            end
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        area_result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_areas.size() == 0)
            begin
                $error("result beat with no prediction waiting");
                error_count++;
            end
            else
            begin
                w = pending_areas.pop_front();
                if (visible_area !== w.area)
                begin
                    $error("visible_area expected %0d actual %0d", w.area, visible_area);
                    error_count++;
                end
                if (overflow !== w.ovf)
                begin
                    $error("overflow expected %0b actual %0b", w.ovf, overflow);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #(HALF_PERIOD * 2 * 3_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        directed_row_t rows [NUM_DIRECTED];
        area_result_t none;
        int gap, burst, sent;
        none = '{'0, 1'b0};
        // Directed table: canvas queries, extremes, every action.
        rows[0]  = '{make_item(orca_pkg::ACT_QUERY, 0, 0, 0, 0, 1), 1,
                     '{32'd4294836225, 1'b0}};
        rows[1]  = '{make_item(orca_pkg::ACT_QUERY, 0, 0, 0, 0, 0), 1, none};
        rows[2]  = '{make_item(orca_pkg::ACT_PAINT, 5, 5, 5, 9, 7), 1, none};
        rows[3]  = '{make_item(orca_pkg::ACT_PAINT, 9, 5, 3, 9, 7), 1, none};
        rows[4]  = '{make_item(orca_pkg::ACT_QUERY, 0, 0, 0, 0, 7), 1, none};
        rows[5]  = '{make_item(orca_pkg::ACT_PAINT, 0, 0, 65535, 65535, 4095), 1, none};
        rows[6]  = '{make_item(orca_pkg::ACT_QUERY, 0, 0, 0, 0, 4095), 1,
                     '{32'd4294836225, 1'b0}};
        rows[7]  = '{make_item(orca_pkg::ACT_QUERY, 0, 0, 0, 0, 1), 1, none};
        rows[8]  = '{make_item(orca_pkg::ACT_PAINT, 10, 20, 30, 40, 2), 0, none};
        rows[9]  = '{make_item(orca_pkg::ACT_PAINT, 25, 0, 65535, 30, 3), 0, none};
        rows[10] = '{make_item(orca_pkg::ACT_QUERY, 0, 0, 0, 0, 2), 0, none};
        rows[11] = '{make_item(orca_pkg::ACT_QUERY, 0, 0, 0, 0, 4095), 0, none};
        rows[12] = '{make_item(ACT_UNUSED, 65535, 65535, 65535, 65535, 4095), 0, none};
        rows[13] = '{make_item(orca_pkg::ACT_RESTART, 0, 0, 0, 0, 0), 1, none};
        rows[14] = '{make_item(orca_pkg::ACT_PAINT, 65534, 65534, 65535, 65535, 2048),
                     0, none};
        rows[15] = '{make_item(orca_pkg::ACT_PAINT, 0, 0, 1, 1, 1365), 0, none};
        rows[16] = '{make_item(orca_pkg::ACT_PAINT, 100, 100, 200, 200, 2730), 0, none};
        rows[17] = '{make_item(orca_pkg::ACT_QUERY, 0, 0, 0, 0, 1), 0, none};
        rows[18] = '{make_item(orca_pkg::ACT_QUERY, 65535, 43690, 21845, 0, 2730),
                     0, none};
        rows[19] = '{make_item(orca_pkg::ACT_RESTART, 0, 0, 0, 0, 0), 1, none};

        reload_canvas();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            push_beat(rows[i].item, rows[i].known, rows[i].want);
            drop_valid();
            @(negedge clk);
        end
        drain();

        // Tiny canvas, zero-size canvas, and a wide one near the top of the area range.
        apb_write(orca_pkg::REG_WIDTH, 32'd64);
        apb_write(orca_pkg::REG_HEIGHT, 32'd64);
        apb_write(orca_pkg::REG_BG, 32'd4095);
        push_beat(make_item(orca_pkg::ACT_RESTART, 0, 0, 0, 0, 0), 0, none);
        push_beat(make_item(orca_pkg::ACT_QUERY, 0, 0, 0, 0, 4095), 1,
                  '{32'd4096, 1'b0});
        drain();
        apb_write(orca_pkg::REG_WIDTH, 32'd0);
        apb_write(orca_pkg::REG_BG, 32'd0);
        push_beat(make_item(orca_pkg::ACT_RESTART, 0, 0, 0, 0, 0), 0, none);
        push_beat(make_item(orca_pkg::ACT_PAINT, 0, 0, 9, 9, 0), 0, none);
        push_beat(make_item(orca_pkg::ACT_QUERY, 0, 0, 0, 0, 0), 1, '{32'd81, 1'b0});
        drain();
        apb_write(orca_pkg::REG_WIDTH, 32'd65535);
        apb_write(orca_pkg::REG_HEIGHT, 32'd65535);
        apb_write(orca_pkg::REG_BG, 32'd5);
        push_beat(make_item(orca_pkg::ACT_RESTART, 0, 0, 0, 0, 0), 0, none);
        push_beat(make_item(orca_pkg::ACT_PAINT, 0, 0, 65535, 1, 5), 0, none);
        push_beat(make_item(orca_pkg::ACT_QUERY, 0, 0, 0, 0, 5), 0, none);
        drain();
        apb_write(orca_pkg::REG_WIDTH, 32'd48);
        apb_write(orca_pkg::REG_HEIGHT, 32'd40);
        apb_write(orca_pkg::REG_BG, 32'd3);
        push_beat(make_item(orca_pkg::ACT_RESTART, 0, 0, 0, 0, 0), 0, none);

        // Random bursts; one long receiver hold-off midway.
        sent = 0;
        while (sent < NUM_RANDOM)
        begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst && sent < NUM_RANDOM; j++)
            begin
                if (sent == NUM_RANDOM / 2)
                    long_hold = 1'b1;
                push_beat(random_item(47), 0, none);
                sent++;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                drop_valid();
                repeat (gap) @(negedge clk);
            end
        end

        // Table-full case: a grid of crossing lines splits every band.
        drain();
        apb_write(orca_pkg::REG_WIDTH, 32'd1024);
        apb_write(orca_pkg::REG_HEIGHT, 32'd1024);
        push_beat(make_item(orca_pkg::ACT_RESTART, 0, 0, 0, 0, 0), 0, none);
        for (int j = 0; j < 32; j++)
        begin
            push_beat(make_item(orca_pkg::ACT_PAINT, j * 16 + 4, 0, j * 16 + 5, 1024,
                                j % 4), 0, none);
            push_beat(make_item(orca_pkg::ACT_PAINT, 0, j * 16 + 4, 1024, j * 16 + 5,
                                (j + 1) % 4), 0, none);
        end
        push_beat(make_item(orca_pkg::ACT_QUERY, 0, 0, 0, 0, 3), 0, none);
        push_beat(make_item(orca_pkg::ACT_QUERY, 0, 0, 0, 0, 2), 0, none);
        push_beat(make_item(orca_pkg::ACT_RESTART, 0, 0, 0, 0, 0), 0, none);
        drain();

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/orca_pkg.sv
rtl/core/overlapping_rectangle_color_area.sv
bench/testbench.sv
